// ----- rtl/mfc_pkg.sv -----
// shared constants for the multipath fading channel
package mfc_pkg;

  localparam int unsigned NUM_TAPS   = 4;
  localparam int unsigned MAX_DELAY  = 64;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned DELAY_W    = 6;
  localparam int unsigned GAIN_W     = 16;

  localparam int unsigned TAP_W      = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
  localparam int unsigned POS_W      = $clog2(MAX_DELAY);
  localparam int unsigned MEM_DEPTH  = NUM_TAPS * MAX_DELAY;
  localparam int unsigned ADDR_W     = $clog2(MEM_DEPTH);

  // register map: delays first, then gains
  localparam int unsigned NUM_REGS       = 2 * NUM_TAPS;
  localparam int unsigned CFG_IDX_W      = $clog2(NUM_REGS) + 1;
  localparam int unsigned CFG_DATA_W     = GAIN_W;
  localparam int unsigned CFG_DELAY_BASE = 0;
  localparam int unsigned CFG_GAIN_BASE  = NUM_TAPS;

endpackage

// ----- rtl/mfc_intf.sv -----
// handshake channels of the multipath fading channel
interface mfc_in_if import mfc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] data_re;
  logic signed [SAMPLE_W-1:0] data_im;
  logic signed [SAMPLE_W-1:0] fade0_re;
  logic signed [SAMPLE_W-1:0] fade0_im;
  logic signed [SAMPLE_W-1:0] fade1_re;
  logic signed [SAMPLE_W-1:0] fade1_im;
  logic signed [SAMPLE_W-1:0] fade2_re;
  logic signed [SAMPLE_W-1:0] fade2_im;
  logic signed [SAMPLE_W-1:0] fade3_re;
  logic signed [SAMPLE_W-1:0] fade3_im;

  modport source (
    output valid, data_re, data_im, fade0_re, fade0_im, fade1_re, fade1_im,
           fade2_re, fade2_im, fade3_re, fade3_im,
    input  ready
  );
  modport sink (
    input  valid, data_re, data_im, fade0_re, fade0_im, fade1_re, fade1_im,
           fade2_re, fade2_im, fade3_re, fade3_im,
    output ready
  );
endinterface

interface mfc_out_if import mfc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] out_re;
  logic signed [SAMPLE_W-1:0] out_im;

  modport source (output valid, out_re, out_im, input ready);
  modport sink (input valid, out_re, out_im, output ready);
endinterface

interface mfc_cfg_if import mfc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

// ----- rtl/multipath_fading_channel_top.sv -----
// tapped delay line multipath fading channel, one memory holding the product history
// Each accepted word is worked tap by tap through one shared complex multiplier, one
// port pair on the product memory and one gain multiplier, so no new word is taken
// until the last has retired; the result sits in an output register, so the next
// word is taken while it waits. The product history (NUM_TAPS x MAX_DELAY complex
// entries) lives in a synchronous memory with a registered read; a valid bit per
// delay slot, cleared by reset, makes unwritten history read as zero, so there is
// no clearing pass after reset. Delays above MAX_DELAY-1 act as MAX_DELAY-1, and a
// zero delay uses the current product through a forwarding path.
// Configuration writes are always taken and must only be issued while the block is idle.
module multipath_fading_channel_top import mfc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  mfc_cfg_if.sink   cfg_i,
  mfc_in_if.sink    in_i,
  mfc_out_if.source out_o
);

  localparam int unsigned MUL_W  = SAMPLE_W + GAIN_W + 1;
  localparam int unsigned ACC_A  = MUL_W + TAP_W + 1;
  localparam int unsigned ACC_B  = 2 * SAMPLE_W + 2;
  localparam int unsigned ACC_W  = (ACC_A > ACC_B) ? ACC_A : ACC_B;
  localparam int unsigned DC_W   = ((DELAY_W > POS_W) ? DELAY_W : POS_W) + 1;

  localparam logic signed [ACC_W-1:0] SMAX     = ACC_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SMIN     = -SMAX - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] PRD_HALF = ACC_W'(1) << (SAMPLE_W - 2);
  localparam logic signed [ACC_W-1:0] OUT_HALF = ACC_W'(1) << (GAIN_W - 1);

  function automatic logic signed [SAMPLE_W-1:0] sat_s(input logic signed [ACC_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > SMAX) begin
      r = SMAX[SAMPLE_W-1:0];
    end else if (v < SMIN) begin
      r = SMIN[SAMPLE_W-1:0];
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  // configuration registers
  logic [DELAY_W-1:0] delay_q [NUM_TAPS];
  logic [GAIN_W-1:0]  gain_q  [NUM_TAPS];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_TAPS; k++) begin
        delay_q[k] <= '0;
        gain_q[k]  <= '0;
      end
    end else if (cfg_i.valid) begin
      for (int k = 0; k < NUM_TAPS; k++) begin
        if (cfg_i.idx == CFG_IDX_W'(CFG_DELAY_BASE + k)) begin
          delay_q[k] <= cfg_i.data[DELAY_W-1:0];
        end
        if (cfg_i.idx == CFG_IDX_W'(CFG_GAIN_BASE + k)) begin
          gain_q[k] <= cfg_i.data[GAIN_W-1:0];
        end
      end
    end
  end

  // input word capture
  logic signed [SAMPLE_W-1:0] fade_re_in [NUM_TAPS];
  logic signed [SAMPLE_W-1:0] fade_im_in [NUM_TAPS];
  logic signed [SAMPLE_W-1:0] data_re_q, data_im_q;
  logic signed [SAMPLE_W-1:0] fade_re_q [NUM_TAPS];
  logic signed [SAMPLE_W-1:0] fade_im_q [NUM_TAPS];

  assign fade_re_in[0] = in_i.fade0_re;
  assign fade_im_in[0] = in_i.fade0_im;
  assign fade_re_in[1] = in_i.fade1_re;
  assign fade_im_in[1] = in_i.fade1_im;
  assign fade_re_in[2] = in_i.fade2_re;
  assign fade_im_in[2] = in_i.fade2_im;
  assign fade_re_in[3] = in_i.fade3_re;
  assign fade_im_in[3] = in_i.fade3_im;

  logic busy_q;
  logic in_acc;

  assign in_i.ready = !busy_q;
  assign in_acc     = in_i.valid && !busy_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      data_re_q <= in_i.data_re;
      data_im_q <= in_i.data_im;
      for (int k = 0; k < NUM_TAPS; k++) begin
        fade_re_q[k] <= fade_re_in[k];
        fade_im_q[k] <= fade_im_in[k];
      end
    end
  end

  // control and pipeline state
  logic             iss_v_q;
  logic [TAP_W-1:0] iss_k_q;
  logic             iss_last;
  logic             s1_v_q, s1_last_q;
  logic [TAP_W-1:0] s1_k_q;
  logic             s2_v_q, s2_last_q;
  logic [TAP_W-1:0] s2_k_q;
  logic             s3_v_q, s3_last_q;
  logic             fin_q;
  logic             fin_go;
  logic             out_vld_q;
  logic [POS_W-1:0] wp_q;
  logic             row_vld_q [MAX_DELAY];

  assign iss_last = iss_k_q == TAP_W'(NUM_TAPS - 1);
  assign fin_go   = fin_q && (!out_vld_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      iss_v_q   <= 1'b0;
      iss_k_q   <= '0;
      s1_v_q    <= 1'b0;
      s1_last_q <= 1'b0;
      s1_k_q    <= '0;
      s2_v_q    <= 1'b0;
      s2_last_q <= 1'b0;
      s2_k_q    <= '0;
      s3_v_q    <= 1'b0;
      s3_last_q <= 1'b0;
      fin_q     <= 1'b0;
      out_vld_q <= 1'b0;
      wp_q      <= '0;
      for (int p = 0; p < MAX_DELAY; p++) begin
        row_vld_q[p] <= 1'b0;
      end
    end else begin
      // tap issue counter
      if (in_acc) begin
        busy_q  <= 1'b1;
        iss_v_q <= 1'b1;
        iss_k_q <= '0;
      end else if (iss_v_q) begin
        if (iss_last) begin
          iss_v_q <= 1'b0;
        end else begin
          iss_k_q <= iss_k_q + TAP_W'(1);
        end
      end

      s1_v_q    <= iss_v_q;
      s1_last_q <= iss_v_q && iss_last;
      s1_k_q    <= iss_k_q;
      s2_v_q    <= s1_v_q;
      s2_last_q <= s1_v_q && s1_last_q;
      s2_k_q    <= s1_k_q;
      s3_v_q    <= s2_v_q;
      s3_last_q <= s2_v_q && s2_last_q;

      if (s3_v_q && s3_last_q) begin
        fin_q <= 1'b1;
      end else if (fin_go) begin
        fin_q <= 1'b0;
      end

      // retire the word: result to the output register, slot becomes history
      if (fin_go) begin
        out_vld_q       <= 1'b1;
        busy_q          <= 1'b0;
        row_vld_q[wp_q] <= 1'b1;
        wp_q            <= (wp_q == POS_W'(MAX_DELAY - 1)) ? '0 : wp_q + POS_W'(1);
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // stage 1: four partial products of data times fading
  logic signed [2*SAMPLE_W-1:0] s1_rr_q, s1_ii_q, s1_ri_q, s1_ir_q;
  logic signed [SAMPLE_W-1:0]   cur_fr, cur_fi;

  assign cur_fr = fade_re_q[iss_k_q];
  assign cur_fi = fade_im_q[iss_k_q];

  always_ff @(posedge clk_i) begin
    s1_rr_q <= data_re_q * cur_fr;
    s1_ii_q <= data_im_q * cur_fi;
    s1_ri_q <= data_re_q * cur_fi;
    s1_ir_q <= data_im_q * cur_fr;
  end

  // stage 2: round and saturate the product, write it, read the delayed one
  logic signed [ACC_W-1:0]    sum_re, sum_im;
  logic signed [SAMPLE_W-1:0] prod_re, prod_im;
  logic [DC_W-1:0]            d_ext;
  logic [POS_W-1:0]           dc;
  logic [POS_W:0]             rp_sum;
  logic [POS_W-1:0]           rp;
  logic [ADDR_W-1:0]          wr_addr, rd_addr;

  assign sum_re  = ACC_W'(s1_rr_q) - ACC_W'(s1_ii_q);
  assign sum_im  = ACC_W'(s1_ri_q) + ACC_W'(s1_ir_q);
  assign prod_re = sat_s((sum_re + PRD_HALF) >>> (SAMPLE_W - 1));
  assign prod_im = sat_s((sum_im + PRD_HALF) >>> (SAMPLE_W - 1));

  assign d_ext   = DC_W'(delay_q[s1_k_q]);
  assign dc      = (d_ext > DC_W'(MAX_DELAY - 1)) ? POS_W'(MAX_DELAY - 1) : d_ext[POS_W-1:0];
  assign rp_sum  = (wp_q >= dc) ? {1'b0, wp_q} - {1'b0, dc}
                                : {1'b0, wp_q} + (POS_W + 1)'(MAX_DELAY) - {1'b0, dc};
  assign rp      = rp_sum[POS_W-1:0];
  assign wr_addr = ADDR_W'(s1_k_q) * ADDR_W'(MAX_DELAY) + ADDR_W'(wp_q);
  assign rd_addr = ADDR_W'(s1_k_q) * ADDR_W'(MAX_DELAY) + ADDR_W'(rp);

  logic [2*SAMPLE_W-1:0] pdl_mem [MEM_DEPTH];
  logic [2*SAMPLE_W-1:0] mem_rd_q;
  logic [2*SAMPLE_W-1:0] s2_prod_q;
  logic                  s2_fwd_q, s2_vld_q;

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      pdl_mem[wr_addr] <= {prod_re, prod_im};
      mem_rd_q         <= pdl_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    s2_prod_q <= {prod_re, prod_im};
    // zero delay takes the product just formed
    s2_fwd_q  <= dc == '0;
    s2_vld_q  <= row_vld_q[rp];
  end

  // stage 3: scale by the tap gain
  logic signed [SAMPLE_W-1:0] smp_re, smp_im;
  logic signed [GAIN_W:0]     gain_s;
  logic signed [MUL_W-1:0]    s3_m_re_q, s3_m_im_q;

  always_comb begin
    if (s2_fwd_q) begin
      smp_re = s2_prod_q[2*SAMPLE_W-1:SAMPLE_W];
      smp_im = s2_prod_q[SAMPLE_W-1:0];
    end else if (s2_vld_q) begin
      smp_re = mem_rd_q[2*SAMPLE_W-1:SAMPLE_W];
      smp_im = mem_rd_q[SAMPLE_W-1:0];
    end else begin
      smp_re = '0;
      smp_im = '0;
    end
  end

  assign gain_s = $signed({1'b0, gain_q[s2_k_q]});

  always_ff @(posedge clk_i) begin
    s3_m_re_q <= smp_re * gain_s;
    s3_m_im_q <= smp_im * gain_s;
  end

  // stage 4: accumulate over taps, then round and saturate on retire
  logic signed [ACC_W-1:0]    acc_re_q, acc_im_q;
  logic signed [SAMPLE_W-1:0] out_re_q, out_im_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (s3_v_q) begin
      acc_re_q <= acc_re_q + ACC_W'(s3_m_re_q);
      acc_im_q <= acc_im_q + ACC_W'(s3_m_im_q);
    end
    if (fin_go) begin
      out_re_q <= sat_s((acc_re_q + OUT_HALF) >>> GAIN_W);
      out_im_q <= sat_s((acc_im_q + OUT_HALF) >>> GAIN_W);
    end
  end

  assign out_o.valid  = out_vld_q;
  assign out_o.out_re = out_re_q;
  assign out_o.out_im = out_im_q;

`ifndef ASSERT_OFF
  a_accept_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !(iss_v_q || s1_v_q || s2_v_q || s3_v_q || fin_q))
    else $error("word accepted while taps still in flight");

  a_fin_flushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> !(iss_v_q || s1_v_q || s2_v_q || s3_v_q))
    else $error("result pending with taps still in flight");

  a_wp_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> (wp_q != $past(wp_q)) && out_vld_q)
    else $error("retire did not advance write position");
`endif

endmodule
